>>> hw/rtl/water_ripple_stencil_core_assert.svh
// Assertion macros shared by the water ripple stencil RTL.
`ifndef WATER_RIPPLE_STENCIL_CORE_ASSERT_SVH
`define WATER_RIPPLE_STENCIL_CORE_ASSERT_SVH

// Same-cycle check, sampled on clk, off while rst_n is low.
`define WRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle check, sampled on clk, off while rst_n is low.
`define WRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/wrs_pkg.sv
// Shared types, constants and codes of the water ripple stencil.
`timescale 1ns / 1ps
`default_nettype none

package wrs_pkg;

    // Default parameter values.
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_FRAC_BITS  = 8;

    // Field and register widths.
    localparam int CHAN_W      = 16;
    localparam int DIM_W       = 11;
    localparam int DAMP_W      = 17;
    localparam int CFG_DATA_W  = 17;
    localparam int CFG_INDEX_W = 2;
    localparam int N_LANES     = 3;

    // Wave arithmetic widths: four-neighbor sum, signed difference, product.
    localparam int SUM_W  = CHAN_W + 2;
    localparam int DIFF_W = SUM_W + 1;
    localparam int PROD_W = SUM_W + DAMP_W;
    // Halving of the sum folded into the Q1.16 scaling.
    localparam int SCALE_SHIFT = 17;

    // Register reset values.
    localparam logic [DIM_W-1:0]  FRAME_WIDTH_RESET  = 11'd800;
    localparam logic [DIM_W-1:0]  FRAME_HEIGHT_RESET = 11'd800;
    localparam logic [DAMP_W-1:0] DAMPING_RESET      = 17'd65536;

    // Smallest usable frame dimension.
    localparam int MIN_DIM = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_DAMPING      = 2'd2
    } cfg_index_t;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef chan_t [N_LANES-1:0] pix_t;   // 0 red, 1 green, 2 blue

    typedef struct packed {
        logic  opcode;
        chan_t last_red;
        chan_t last_green;
        chan_t last_blue;
        chan_t older_red;
        chan_t older_green;
        chan_t older_blue;
    } in_item_t;

    typedef struct packed {
        chan_t new_red;
        chan_t new_green;
        chan_t new_blue;
        logic  frame_end;
    } out_item_t;

    // What one pipeline slot does when it reaches the merge stage.
    typedef struct packed {
        logic emit_held;   // emit the held result
        logic emit_lane;   // emit the lane value (drain of the last row)
        logic load_held;   // lane value becomes the held result
        logic frame_end;
        logic pass;        // lanes pass the older value through
    } slot_ctrl_t;

    // Per-stage load enables for the lanes.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } lane_en_t;

endpackage

`default_nettype wire

>>> hw/rtl/water_ripple_stencil_core.sv
// Top level of the water ripple stencil: position control, pipeline control, lanes.
`timescale 1ns / 1ps
`default_nettype none
`include "water_ripple_stencil_core_assert.svh"

// Water ripple stencil core. Takes pixels of the last frame in raster order, each with the
// same pixel of the frame before, and returns the next frame: for interior pixels
// ((up + down + left + right) / 2 - older) * damping_factor (Q1.16), floored and clamped to
// 0 .. 255 in 8.FRAC_BITS; border pixels return the older value. Throughput is one beat per
// clock while the output is not stalled: three row stores with registered reads that
// prefetch the next column keep the three-by-three window fed, and three channel lanes of
// three register stages each run side by side, so a beat can enter every cycle. A result
// beat leaves one item after the pixel that made it (one row plus one pixel behind in the
// frame); after the frame's last pixel, frame_width + 1 flush beats drain the last row, the
// final one flagged frame_end. The input side keeps accepting until the three pipeline
// stages are full behind a stalled output. Writing frame_width or frame_height restarts
// the frame position; write registers only while the block is idle. The row stores hold
// no reset contents and need no clearing pass: no result reads an unwritten entry.

module water_ripple_stencil_core
    import wrs_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_item_t              out_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);        // column index
    localparam int WW = $clog2(MAX_WIDTH + 1);    // width value
    localparam int RW = $clog2(MAX_HEIGHT);       // row index
    localparam int HW = $clog2(MAX_HEIGHT + 1);   // height value
    localparam int PW = $clog2(MAX_WIDTH + 2);    // drain count, up to width + 1

    // Configuration registers.
    logic [DIM_W-1:0]  frame_width_reg;
    logic [DIM_W-1:0]  frame_height_reg;
    logic [DAMP_W-1:0] damping_reg;

    // Frame position and drain state.
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [PW-1:0] pend_reg, pend_next;
    logic          held_valid_reg, held_valid_next;

    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [WW-1:0] c_inc;
    logic [HW-1:0] r_inc;
    logic          col_wrap;
    logic          row_wrap;
    logic [PW-1:0] pend_full;

    logic in_accept;
    logic pixel_acc;
    logic flush_acc;
    logic cfg_restart;

    // Slot entering the pipeline with this beat.
    logic       slot_valid;
    slot_ctrl_t slot;

    // Three-stage pipeline control, stage payload in the lanes.
    logic       v1_reg, v2_reg, v3_reg;
    slot_ctrl_t c1_reg, c2_reg, c3_reg;
    logic       take1, take2, take3;
    logic       adv1, adv2, adv3;
    lane_en_t   lane_en;

    // Row store connections.
    logic [CW-1:0] older_col;
    logic [CW-1:0] rd_col_right;
    pix_t          last_pix;
    pix_t          older_pix;
    pix_t          upper_rd;
    pix_t          mid_right_rd;
    pix_t          older_rd;
    pix_t          left_rd;
    pix_t          lane_value;

    //--------------------------------------------------------------------
    // Configuration port
    //--------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
            damping_reg      <= DAMPING_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[DIM_W-1:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[DIM_W-1:0];
                CFG_DAMPING:      damping_reg      <= cfg_data[DAMP_W-1:0];
                default:          ;   // unused index, write dropped
            endcase
        end
    end

    // Dimensions in use: clamped to MIN_DIM .. MAX.
    always_comb
    begin
        if (32'(frame_width_reg) < MIN_DIM)
            w_eff = WW'(MIN_DIM);
        else if (32'(frame_width_reg) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(frame_width_reg);

        if (32'(frame_height_reg) < MIN_DIM)
            h_eff = HW'(MIN_DIM);
        else if (32'(frame_height_reg) > MAX_HEIGHT)
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(frame_height_reg);
    end

    //--------------------------------------------------------------------
    // Position, drain and slot decode
    //--------------------------------------------------------------------
    always_comb
    begin
        in_accept   = in_valid && in_ready;
        pixel_acc   = in_accept && (in_data.opcode == OP_PIXEL);
        flush_acc   = in_accept && (in_data.opcode == OP_FLUSH);
        cfg_restart = cfg_we && (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT);
        c_inc       = WW'(col_reg) + WW'(1);
        r_inc       = HW'(row_reg) + HW'(1);
        col_wrap    = (c_inc >= w_eff);
        row_wrap    = (r_inc >= h_eff);
        pend_full   = PW'(w_eff) + PW'(1);
    end

    always_comb
    begin
        col_next        = col_reg;
        row_next        = row_reg;
        pend_next       = pend_reg;
        held_valid_next = held_valid_reg;
        slot_valid      = 1'b0;
        slot            = '0;

        if (cfg_restart)
        begin
            col_next        = '0;
            row_next        = '0;
            pend_next       = '0;
            held_valid_next = 1'b0;
        end
        else if (pixel_acc)
        begin
            // A pixel drops anything left to drain; it then starts the frame at the origin.
            pend_next       = '0;
            // The window centers one row up; that row's first line is the top border.
            slot_valid      = held_valid_reg || (row_reg != '0);
            slot.emit_held  = held_valid_reg;
            slot.load_held  = (row_reg != '0);
            slot.pass       = (row_reg == RW'(1)) || (col_reg == '0) || col_wrap;
            held_valid_next = (row_reg != '0);
            if (col_wrap)
            begin
                col_next = '0;
                if (row_wrap)
                begin
                    row_next        = '0;
                    pend_next       = pend_full;
                    held_valid_next = 1'b0;   // last result goes out with the first flush
                end
                else
                begin
                    row_next = RW'(r_inc);
                end
            end
            else
            begin
                col_next = CW'(c_inc);
            end
        end
        else if (flush_acc && (pend_reg != '0))
        begin
            pend_next  = pend_reg - PW'(1);
            slot_valid = 1'b1;
            if (pend_reg == pend_full)
            begin
                slot.emit_held = 1'b1;
            end
            else
            begin
                // Bottom row is all border: its older values come straight out.
                slot.emit_lane = 1'b1;
                slot.pass      = 1'b1;
                slot.frame_end = (pend_reg == PW'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            pend_reg       <= '0;
            held_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            pend_reg       <= pend_next;
            held_valid_reg <= held_valid_next;
        end
    end

    //--------------------------------------------------------------------
    // Row stores. Reads prefetch the column of the next beat; while draining,
    // the older store steps through the last row instead.
    //--------------------------------------------------------------------
    always_comb
    begin
        rd_col_right = CW'(WW'(col_next) + WW'(1));
        if (pend_next != '0 && pend_next != pend_full)
            older_col = CW'(PW'(w_eff) - pend_next);
        else
            older_col = col_next;

        last_pix[0]  = in_data.last_red;
        last_pix[1]  = in_data.last_green;
        last_pix[2]  = in_data.last_blue;
        older_pix[0] = in_data.older_red;
        older_pix[1] = in_data.older_green;
        older_pix[2] = in_data.older_blue;
    end

    wrs_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .clk          (clk),
        .wr_en        (pixel_acc),
        .wr_col       (col_reg),
        .last         (last_pix),
        .older        (older_pix),
        .rd_col       (col_next),
        .rd_col_right (rd_col_right),
        .older_col    (older_col),
        .upper_rd     (upper_rd),
        .mid_right_rd (mid_right_rd),
        .older_rd     (older_rd),
        .left_rd      (left_rd)
    );

    //--------------------------------------------------------------------
    // Pipeline control: each stage fills whenever it is empty or moving on,
    // so bubbles collapse behind a stalled output.
    //--------------------------------------------------------------------
    always_comb
    begin
        take3      = !v3_reg || adv3;
        adv2       = v2_reg && take3;
        take2      = !v2_reg || adv2;
        adv1       = v1_reg && take2;
        take1      = !v1_reg || adv1;
        in_ready   = take1;
        lane_en.s1 = take1;
        lane_en.s2 = take2;
        lane_en.s3 = take3;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (take1)
                v1_reg <= slot_valid;
            if (take2)
                v2_reg <= v1_reg;
            if (take3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take1)
            c1_reg <= slot;
        if (take2)
            c2_reg <= c1_reg;
        if (take3)
            c3_reg <= c2_reg;
    end

    //--------------------------------------------------------------------
    // Channel lanes: window is up, this pixel below, left and right on the
    // centered row.
    //--------------------------------------------------------------------
    for (genvar i = 0; i < N_LANES; i++)
    begin : g_lane
        wrs_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk     (clk),
            .en      (lane_en),
            .damping (damping_reg),
            .pass    (slot.pass),
            .up      (upper_rd[i]),
            .down    (last_pix[i]),
            .left    (left_rd[i]),
            .right   (mid_right_rd[i]),
            .older   (older_rd[i]),
            .value   (lane_value[i])
        );
    end

    wrs_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .slot_valid (v3_reg),
        .ctrl       (c3_reg),
        .value      (lane_value),
        .out_ready  (out_ready),
        .advance    (adv3),
        .out_valid  (out_valid),
        .out_data   (out_data)
    );

    //--------------------------------------------------------------------
    // Assertions
    //--------------------------------------------------------------------
    `WRS_ASSERT_NOW(a_drain_at_origin, pend_reg != '0, (col_reg == '0) && (row_reg == '0),
        "drain pending away from frame origin")
    `WRS_ASSERT_NOW(a_drain_no_held, pend_reg != '0, !held_valid_reg,
        "held result marked valid while draining")
    `WRS_ASSERT_NOW(a_col_in_frame, 1'b1, WW'(col_reg) < w_eff,
        "column position outside frame width")
    `WRS_ASSERT_NEXT(a_first_flush_held,
        flush_acc && !cfg_restart && (pend_reg == pend_full),
        v1_reg && c1_reg.emit_held,
        "first flush beat did not queue the held result")

endmodule

`default_nettype wire

>>> hw/rtl/wrs_line_store.sv
// Row stores of the stencil: upper, middle and older rows with registered reads.
`timescale 1ns / 1ps
`default_nettype none

module wrs_line_store
    import wrs_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    localparam int CW = $clog2(MAX_WIDTH)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [CW-1:0] wr_col,
    input  pix_t          last,
    input  pix_t          older,
    input  logic [CW-1:0] rd_col,
    input  logic [CW-1:0] rd_col_right,
    input  logic [CW-1:0] older_col,
    output pix_t          upper_rd,
    output pix_t          mid_right_rd,
    output pix_t          older_rd,
    output pix_t          left_rd
);

    pix_t upper_mem  [MAX_WIDTH];
    pix_t middle_mem [MAX_WIDTH];
    pix_t older_mem  [MAX_WIDTH];

    pix_t upper_rd_reg;
    pix_t mid_cur_rd_reg;
    pix_t mid_right_rd_reg;
    pix_t older_rd_reg;
    pix_t left_reg;

    // Reads look at the next column; writes hit the current one, never the same entry.
    always_ff @(posedge clk)
    begin
        upper_rd_reg     <= upper_mem[rd_col];
        mid_cur_rd_reg   <= middle_mem[rd_col];
        mid_right_rd_reg <= middle_mem[rd_col_right];
        older_rd_reg     <= older_mem[older_col];
        if (wr_en)
        begin
            upper_mem[wr_col]  <= mid_cur_rd_reg;
            middle_mem[wr_col] <= last;
            older_mem[wr_col]  <= older;
            left_reg           <= mid_cur_rd_reg;  // upper entry of the column just written
        end
    end

    assign upper_rd     = upper_rd_reg;
    assign mid_right_rd = mid_right_rd_reg;
    assign older_rd     = older_rd_reg;
    assign left_rd      = left_reg;

endmodule

`default_nettype wire

>>> hw/rtl/wrs_lane.sv
// One color channel of the wave update: difference, damping multiply, clamp.
`timescale 1ns / 1ps
`default_nettype none

module wrs_lane
    import wrs_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic              clk,
    input  lane_en_t          en,
    input  logic [DAMP_W-1:0] damping,
    input  logic              pass,
    input  chan_t             up,
    input  chan_t             down,
    input  chan_t             left,
    input  chan_t             right,
    input  chan_t             older,
    output chan_t             value
);

    localparam chan_t OutMax = CHAN_W'((32'd255 << FRAC_BITS) & 32'hFFFF);

    logic [SUM_W-1:0]  sum;
    logic [DIFF_W-1:0] diff_next;
    logic [DIFF_W-1:0] diff_reg;
    logic              pass1_reg;
    chan_t             older1_reg;

    logic              positive;
    logic [PROD_W-1:0] prod_next;
    logic [PROD_W-1:0] prod_reg;
    logic              pass2_reg;
    chan_t             older2_reg;

    logic [PROD_W-SCALE_SHIFT-1:0] scaled;
    chan_t                         value_next;
    chan_t                         value_reg;

    // Sum kept whole, twice the older value taken off: the halving stays exact.
    always_comb
    begin
        sum       = SUM_W'(up) + SUM_W'(down) + SUM_W'(left) + SUM_W'(right);
        diff_next = DIFF_W'(sum) - DIFF_W'({older, 1'b0});
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            diff_reg   <= diff_next;
            pass1_reg  <= pass;
            older1_reg <= older;
        end
    end

    always_comb
    begin
        positive  = !diff_reg[DIFF_W-1] && (diff_reg != '0);
        prod_next = positive ? PROD_W'(diff_reg[SUM_W-1:0]) * PROD_W'(damping) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            prod_reg   <= prod_next;
            pass2_reg  <= pass1_reg;
            older2_reg <= older1_reg;
        end
    end

    always_comb
    begin
        scaled = prod_reg[PROD_W-1:SCALE_SHIFT];
        if (pass2_reg)
            value_next = older2_reg;
        else if (scaled > (PROD_W-SCALE_SHIFT)'(OutMax))
            value_next = OutMax;
        else
            value_next = CHAN_W'(scaled);
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
            value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire

>>> hw/rtl/wrs_merge.sv
// Merge stage: combines the lane values, keeps the held result, drives the output beat.
`timescale 1ns / 1ps
`default_nettype none

module wrs_merge
    import wrs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       slot_valid,
    input  slot_ctrl_t ctrl,
    input  pix_t       value,
    input  logic       out_ready,
    output logic       advance,
    output logic       out_valid,
    output out_item_t  out_data
);

    pix_t      held_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_data_reg;
    out_item_t out_data_next;
    logic      emit;
    logic      out_free;

    always_comb
    begin
        emit     = ctrl.emit_held || ctrl.emit_lane;
        out_free = !out_valid_reg || out_ready;
        advance  = slot_valid && (!emit || out_free);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (advance && emit)
        begin
            out_valid_next          = 1'b1;
            out_data_next.new_red   = ctrl.emit_held ? held_reg[0] : value[0];
            out_data_next.new_green = ctrl.emit_held ? held_reg[1] : value[1];
            out_data_next.new_blue  = ctrl.emit_held ? held_reg[2] : value[2];
            out_data_next.frame_end = ctrl.frame_end;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Held result is read for this slot's beat before this slot replaces it.
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (advance && ctrl.load_held)
            held_reg <= value;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

>>> test/tb_water_ripple_stencil_core.sv
// Self-checking testbench for the water ripple stencil core, with its own stencil tracker.
`timescale 1ns / 1ps

module tb_water_ripple_stencil_core;
    import wrs_pkg::*;

    localparam int MAX_W = DEF_MAX_WIDTH;
    localparam int MAX_H = DEF_MAX_HEIGHT;
    localparam int DIM_FLOOR = 3;
    // Clamp ceiling of a new channel value: 255 in 8.FRAC_BITS.
    localparam longint unsigned CHAN_CEIL = (64'd255 << DEF_FRAC_BITS) & 64'hFFFF;
    // Quiet wait after every owed result is out, before touching registers.
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS = 400;

    // Tracks the frame position and row stores, and queues the new pixels the core owes.
    class wave_stencil_tracker;
        pix_t upper_row [MAX_W];
        pix_t middle_row [MAX_W];
        pix_t older_row [MAX_W];
        int unsigned pos_col;
        int unsigned pos_row;
        int unsigned drain_left;
        pix_t held_pix;
        bit held_ok;
        logic [DIM_W-1:0] width_reg;
        logic [DIM_W-1:0] height_reg;
        logic [DAMP_W-1:0] damp_reg;
        out_item_t new_pixel_q[$];
        int unsigned failures;
        int unsigned accepted;
        int unsigned checked;
        int unsigned frames;

        function new();
            width_reg = 11'd800;
            height_reg = 11'd800;
            damp_reg = 17'd65536;
            failures = 0;
            accepted = 0;
            checked = 0;
            frames = 0;
            clear_position();
        endfunction

        function void clear_position();
            pos_col = 0;
            pos_row = 0;
            drain_left = 0;
            held_ok = 1'b0;
            held_pix = '0;
        endfunction

        function int unsigned cur_width();
            if (width_reg < DIM_FLOOR)
                return DIM_FLOOR;
            if (width_reg > MAX_W)
                return MAX_W;
            return width_reg;
        endfunction

        function int unsigned cur_height();
            if (height_reg < DIM_FLOOR)
                return DIM_FLOOR;
            if (height_reg > MAX_H)
                return MAX_H;
            return height_reg;
        endfunction

        function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_FRAME_WIDTH:
                begin
                    width_reg = val[DIM_W-1:0];
                    clear_position();
                end
                CFG_FRAME_HEIGHT:
                begin
                    height_reg = val[DIM_W-1:0];
                    clear_position();
                end
                CFG_DAMPING:
                    damp_reg = val[DAMP_W-1:0];
                default:
                    ;
            endcase
        endfunction

        // Sum kept whole, twice the older value taken off, so the halving is exact.
        function chan_t wave_channel(chan_t up, chan_t down, chan_t left, chan_t right,
                                     chan_t older);
            longint diff;
            longint unsigned scaled;
            diff = longint'(up) + longint'(down) + longint'(left) + longint'(right)
                 - 2 * longint'(older);
            if (diff <= 0)
                return '0;
            scaled = (longint'(diff) * longint'(damp_reg)) >> SCALE_SHIFT;
            if (scaled > CHAN_CEIL)
                scaled = CHAN_CEIL;
            return chan_t'(scaled);
        endfunction

        function out_item_t to_result(pix_t p, bit fe);
            out_item_t r;
            r.new_red = p[0];
            r.new_green = p[1];
            r.new_blue = p[2];
            r.frame_end = fe;
            return r;
        endfunction

        function void absorb_input(in_item_t item);
            int unsigned w;
            int unsigned h;
            int unsigned c;
            int unsigned r;
            int unsigned k;
            pix_t cur;
            pix_t old;
            pix_t res;
            bit on_border;
            w = cur_width();
            h = cur_height();
            if (item.opcode == OP_FLUSH)
            begin
                // flush with nothing to drain is dropped
                if (drain_left == 0)
                    return;
                accepted++;
                k = w + 1 - drain_left;
                drain_left--;
                if (k == 0)
                    new_pixel_q.push_back(to_result(held_pix, 1'b0));
                else
                    new_pixel_q.push_back(to_result(older_row[(k - 1) % MAX_W], k == w));
                return;
            end
            accepted++;
            drain_left = 0;
            cur = {item.last_blue, item.last_green, item.last_red};
            old = {item.older_blue, item.older_green, item.older_red};
            c = (pos_col >= w) ? w - 1 : pos_col;
            r = (pos_row >= h) ? h - 1 : pos_row;
            if (held_ok)
                new_pixel_q.push_back(to_result(held_pix, 1'b0));
            if (r >= 1)
            begin
                on_border = (r == 1) || (c == 0) || (c == w - 1);
                for (int i = 0; i < N_LANES; i++)
                begin
                    if (on_border)
                        res[i] = older_row[c][i];
                    else
                        res[i] = wave_channel(upper_row[c][i], cur[i], upper_row[c - 1][i],
                                              middle_row[c + 1][i], older_row[c][i]);
                end
                held_pix = res;
                held_ok = 1'b1;
            end
            else
            begin
                held_ok = 1'b0;
            end
            upper_row[c] = middle_row[c];
            middle_row[c] = cur;
            older_row[c] = old;
            c++;
            if (c >= w)
            begin
                c = 0;
                r++;
                if (r >= h)
                begin
                    r = 0;
                    drain_left = w + 1;
                    held_ok = 1'b0;
                    frames++;
                end
            end
            pos_col = c;
            pos_row = r;
        endfunction

        function void compare_result(out_item_t got);
            out_item_t want;
            if (new_pixel_q.size() == 0)
            begin
                $error("result beat %h arrived with nothing expected", got);
                failures++;
                return;
            end
            want = new_pixel_q.pop_front();
            checked++;
            if (got.new_red !== want.new_red)
            begin
                $error("new_red expected %h actual %h", want.new_red, got.new_red);
                failures++;
            end
            if (got.new_green !== want.new_green)
            begin
                $error("new_green expected %h actual %h", want.new_green, got.new_green);
                failures++;
            end
            if (got.new_blue !== want.new_blue)
            begin
                $error("new_blue expected %h actual %h", want.new_blue, got.new_blue);
                failures++;
            end
            if (got.frame_end !== want.frame_end)
            begin
                $error("frame_end expected %b actual %b", want.frame_end, got.frame_end);
                failures++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_item_t out_data;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Idle percentages of the current phase.
    int unsigned send_idle_pct = 0;
    int unsigned ready_stall_pct = 0;
    int unsigned phases = 0;

    wave_stencil_tracker stencil;

    water_ripple_stencil_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Receiver back-pressure, redrawn every cycle.
    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= ready_stall_pct);

    // Both monitors read pre-edge values; all drivers move by nonblocking update.
    always @(posedge clk)
        if (rst_n && in_valid && in_ready)
            stencil.absorb_input(in_data);

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            stencil.compare_result(out_data);

    // Full 16-bit range, weighted toward the in-range values and the corners.
    function automatic chan_t rand_chan();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return chan_t'(CHAN_CEIL);
            2: return 16'hFFFF;
            3, 4: return chan_t'($urandom);
            default: return chan_t'($urandom_range(0, 65280));
        endcase
    endfunction

    function automatic in_item_t pixel_beat(pix_t cur, pix_t old);
        in_item_t item;
        item.opcode = OP_PIXEL;
        item.last_red = cur[0];
        item.last_green = cur[1];
        item.last_blue = cur[2];
        item.older_red = old[0];
        item.older_green = old[1];
        item.older_blue = old[2];
        return item;
    endfunction

    // Random gap first, then valid held with a steady payload until the handshake.
    task automatic send_beat(input in_item_t item);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_random_pixel();
        send_beat(pixel_beat({rand_chan(), rand_chan(), rand_chan()},
                             {rand_chan(), rand_chan(), rand_chan()}));
    endtask

    // Flush carries junk in the pixel fields; the core must ignore them.
    task automatic send_flush();
        logic [127:0] noise;
        in_item_t item;
        noise = {$urandom, $urandom, $urandom, $urandom};
        item = noise[$bits(in_item_t)-1:0];
        item.opcode = OP_FLUSH;
        send_beat(item);
    endtask

    // Stop sending, let every owed result out, then give the pipe time to go quiet.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (stencil.new_pixel_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // One register write, then the enable goes low again before the task returns.
    task automatic write_cfg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        stencil.write_reg(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Dimension writes carry junk above bit 10.
    task automatic apply_dims(input logic [DIM_W-1:0] w_raw, input logic [DIM_W-1:0] h_raw,
                              input logic [DAMP_W-1:0] damp);
        write_cfg(CFG_FRAME_WIDTH, {6'($urandom), w_raw});
        write_cfg(CFG_FRAME_HEIGHT, {6'($urandom), h_raw});
        write_cfg(CFG_DAMPING, damp);
    endtask

    task automatic set_idling(input int unsigned mode);
        case (mode)
            0:
            begin
                send_idle_pct = 0;
                ready_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct = 51;
                ready_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct = 0;
                ready_stall_pct = 51;
            end
            default:
            begin
                send_idle_pct = 24;
                ready_stall_pct = 24;
            end
        endcase
    endtask

    // Pixels in raster order, then flush beats; pause_at > 0 holds off the sender
    // mid-frame until every owed result is out.
    task automatic run_frame(input int unsigned pixels, input int unsigned flushes,
                             input int unsigned pause_at);
        for (int i = 0; i < pixels; i++)
        begin
            if (pause_at != 0 && i == pause_at)
                wait_drained();
            send_random_pixel();
        end
        for (int i = 0; i < flushes; i++)
            send_flush();
    endtask

    initial
    begin
        int unsigned w;
        int unsigned h;
        int unsigned start;
        int unsigned guard;
        int unsigned kind;
        int unsigned nframes;
        logic [DIM_W-1:0] w_raw;
        logic [DIM_W-1:0] h_raw;
        logic [DAMP_W-1:0] damp;

        stencil = new();
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: 800 wide, so a short run stays in the first row and owes nothing.
        for (int i = 0; i < 12; i++)
            send_random_pixel();
        wait_drained();

        // Directed, 3x3 frames at the reset damping.
        write_cfg(CFG_FRAME_WIDTH, 17'd3);
        write_cfg(CFG_FRAME_HEIGHT, 17'd3);
        // flush with nothing pending: no result
        send_flush();
        // all-max last frame, zero older: interior saturates, borders pass zero
        repeat (9)
            send_beat(pixel_beat({3{16'hFFFF}}, '0));
        repeat (4)
            send_flush();
        // zero last frame, all-max older: interior goes negative to zero, borders pass 0xFFFF
        repeat (9)
            send_beat(pixel_beat('0, {3{16'hFFFF}}));
        repeat (2)
            send_flush();
        // pixel while results pending: drain dropped, new frame begins
        send_random_pixel();
        wait_drained();

        // Size and damping extremes: widest clamp mid-row, tallest clamp over ten rows.
        set_idling(0);
        apply_dims(11'd2047, 11'd0, 17'd131071);
        run_frame(20, 2, 0);
        wait_drained();
        set_idling(3);
        apply_dims(11'd3, 11'd2047, 17'd0);
        run_frame(3 * 10, 4, 0);
        wait_drained();
        set_idling(1);
        apply_dims(11'd1, 11'd2, 17'd1);
        run_frame(9, 4, 0);
        wait_drained();

        // Random phases: mostly whole frames, with cut drains, stray flushes and
        // abandoned frames mixed in.
        start = stencil.accepted;
        while (stencil.accepted - start < RANDOM_ITEMS)
        begin
            wait_drained();
            set_idling(phases % 4);
            case ($urandom_range(0, 9))
                0: w_raw = DIM_W'($urandom_range(0, 2));
                1: w_raw = DIM_W'($urandom_range(9, 16));
                default: w_raw = DIM_W'($urandom_range(3, 8));
            endcase
            case ($urandom_range(0, 9))
                0: h_raw = DIM_W'($urandom_range(0, 2));
                default: h_raw = DIM_W'($urandom_range(3, 6));
            endcase
            case ($urandom_range(0, 7))
                0: damp = '0;
                1: damp = 17'd65536;
                2: damp = 17'd131071;
                3: damp = DAMP_W'($urandom_range(60000, 65536));
                default: damp = DAMP_W'($urandom);
            endcase
            apply_dims(w_raw, h_raw, damp);
            w = stencil.cur_width();
            h = stencil.cur_height();
            nframes = $urandom_range(1, 3);
            for (int f = 0; f < nframes; f++)
            begin
                kind = $urandom_range(0, 9);
                if (phases == 0 && f == 0)
                begin
                    run_frame(w * h, w + 1, (w * h) / 2);
                end
                else if (kind == 0)
                begin
                    // abandoned frame; a height rewrite restarts the position
                    run_frame($urandom_range(1, w * h - 1), $urandom_range(0, 2), 0);
                    wait_drained();
                    write_cfg(CFG_FRAME_HEIGHT, {6'($urandom), h_raw});
                end
                else if (kind == 1)
                begin
                    // drain cut short, next pixel drops the rest
                    run_frame(w * h, $urandom_range(0, w), 0);
                end
                else if (kind == 2)
                begin
                    // extra flushes after the drain are ignored
                    run_frame(w * h, w + 1 + $urandom_range(1, 3), 0);
                end
                else
                begin
                    run_frame(w * h, w + 1, 0);
                end
            end
            phases++;
        end

        // Wind down: everything owed must show up, then the pipe gets time to go quiet.
        in_valid <= 1'b0;
        guard = 0;
        while (stencil.new_pixel_q.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (stencil.new_pixel_q.size() != 0)
        begin
            $error("%0d expected result beats never arrived", stencil.new_pixel_q.size());
            stencil.failures++;
        end

        $display("Sent %0d effective input beats: reset-default row, 3x3 corner frames, %s",
                 stencil.accepted, "clamped sizes, damping 0 to above one");
        $display("Checked %0d result beats over %0d completed frames in %0d random phases",
                 stencil.checked, stencil.frames, phases);
        if (stencil.failures == 0)
            $display("water_ripple_stencil_core test passed");
        else
            $display("water_ripple_stencil_core test failed");
        $finish;
    end

    // Watchdog, far above the slowest legal run.
    initial
    begin
        #5000000;
        $display("water_ripple_stencil_core test failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/wrs_pkg.sv
hw/rtl/wrs_line_store.sv
hw/rtl/wrs_lane.sv
hw/rtl/wrs_merge.sv
hw/rtl/water_ripple_stencil_core.sv
test/tb_water_ripple_stencil_core.sv
